>>> src/vmmio_pkg.sv
// Shared constants, codes and types for the legacy virtio MMIO register block.
package vmmio_pkg;

  // Item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_RAISE = 2'd2;

  // Register offsets within the 4 KiB window
  localparam logic [11:0] OFF_MAGIC       = 12'h000;
  localparam logic [11:0] OFF_VERSION     = 12'h004;
  localparam logic [11:0] OFF_DEVICE_ID   = 12'h008;
  localparam logic [11:0] OFF_VENDOR_ID   = 12'h00c;
  localparam logic [11:0] OFF_HOST_FEAT   = 12'h010;
  localparam logic [11:0] OFF_HOST_SEL    = 12'h014;
  localparam logic [11:0] OFF_GUEST_FEAT  = 12'h020;
  localparam logic [11:0] OFF_GUEST_SEL   = 12'h024;
  localparam logic [11:0] OFF_PAGE_SIZE   = 12'h028;
  localparam logic [11:0] OFF_QUEUE_SEL   = 12'h030;
  localparam logic [11:0] OFF_QUEUE_MAX   = 12'h034;
  localparam logic [11:0] OFF_QUEUE_NUM   = 12'h038;
  localparam logic [11:0] OFF_QUEUE_ALIGN = 12'h03c;
  localparam logic [11:0] OFF_QUEUE_PFN   = 12'h040;
  localparam logic [11:0] OFF_QUEUE_NOTE  = 12'h050;
  localparam logic [11:0] OFF_INT_STATUS  = 12'h060;
  localparam logic [11:0] OFF_INT_ACK     = 12'h064;
  localparam logic [11:0] OFF_STATUS      = 12'h070;
  localparam logic [11:0] CONFIG_BASE     = 12'h100;

  // Fixed register values
  localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
  localparam logic [31:0] VERSION_VALUE = 32'h0000_0001;
  localparam logic [31:0] VENDOR_VALUE  = 32'h554D_4551;
  localparam logic [31:0] MAX_RING_SIZE = 32'd1024;
  localparam logic [2:0]  REG_BYTES     = 3'd4;

  // Configuration register indexes (APB byte address bit 2)
  localparam logic CFG_DEVICE_ID = 1'b0;
  localparam logic CFG_FEATURES  = 1'b1;

  localparam int QUEUE_COUNT_DEF = 64;

  // One queue table entry: written PFN and the page shift in force at write time
  typedef struct packed {
    logic [4:0]  shift;
    logic [31:0] pfn;
  } qentry_t;

endpackage

>>> src/vmmio_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vmmio_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/virtio_mmio_transport_registers_core.sv
// An accepted transfer passes through the input register and then the result register.
// Throughput: one transfer per cycle unless the result stalls; the queue table RAM is read every
// cycle at the next selected queue, with a one-entry bypass for a write made in the cycle before.
// Reset (rst, synchronous): clears all control and transport state and the per-queue valid
// bits at once, so queue addresses read as zero; no clearing pass, items are taken right away.
module virtio_mmio_transport_registers_core #(
  parameter int QUEUE_COUNT = vmmio_pkg::QUEUE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [11:0] reg_offset,
  input  logic [2:0]  access_bytes,
  input  logic [31:0] write_value,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] read_data,
  output logic        irq_level,
  output logic        notify_valid,
  output logic [5:0]  notify_queue,
  output logic        features_valid,
  output logic [31:0] accepted_features,
  output logic        reset_pulse,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  // configuration registers
  logic [7:0]  device_type_id;
  logic [31:0] offered_features;

  // transport state
  logic [31:0]            host_select, host_select_next;
  logic [31:0]            guest_select, guest_select_next;
  logic [4:0]             page_shift, page_shift_next;
  logic [QW-1:0]          selected_queue, selected_queue_next;
  logic [7:0]             interrupt_status, interrupt_status_next;
  logic [7:0]             device_status, device_status_next;
  logic [QUEUE_COUNT-1:0] qvalid, qvalid_next;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [11:0] s1_offset;
  logic [2:0]  s1_bytes;
  logic [31:0] s1_value;

  // queue table
  vmmio_pkg::qentry_t ram_rdata, ram_wdata, byp_data, qentry;
  logic               ram_we, byp_hit;
  logic [31:0]        qread;

  // result values
  logic [31:0] rdata_c, fbits_c;
  logic        nvalid_c, fvalid_c, rpulse_c;
  logic [5:0]  nqueue_c;
  logic        adv, reg_access, dev_reset;

  // trailing zero count; zero input gives zero
  function automatic logic [4:0] ctz32(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  // flow control
  assign adv       = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
    if (req_valid && !req_stall) begin
      s1_kind   <= kind;
      s1_offset <= reg_offset;
      s1_bytes  <= access_bytes;
      s1_value  <= write_value;
    end
  end

  // current queue entry with bypass of last cycle's write
  assign qentry = byp_hit ? byp_data : ram_rdata;
  assign qread  = qvalid[selected_queue]
                ? 32'((64'(qentry.pfn) << qentry.shift) >> page_shift) : 32'd0;

  // decode and state update
  always_comb begin
    host_select_next      = host_select;
    guest_select_next     = guest_select;
    page_shift_next       = page_shift;
    selected_queue_next   = selected_queue;
    interrupt_status_next = interrupt_status;
    device_status_next    = device_status;
    qvalid_next           = qvalid;
    rdata_c   = 32'd0;
    fbits_c   = 32'd0;
    nvalid_c  = 1'b0;
    fvalid_c  = 1'b0;
    rpulse_c  = 1'b0;
    nqueue_c  = 6'd0;
    ram_we    = 1'b0;
    dev_reset = 1'b0;
    ram_wdata = '{shift: page_shift, pfn: s1_value};
    reg_access = (s1_offset < vmmio_pkg::CONFIG_BASE) && (s1_bytes == vmmio_pkg::REG_BYTES);

    if (adv) begin
      case (s1_kind)
        vmmio_pkg::KIND_READ: begin
          if (reg_access) begin
            case (s1_offset)
              vmmio_pkg::OFF_MAGIC:      rdata_c = vmmio_pkg::MAGIC_VALUE;
              vmmio_pkg::OFF_VERSION:    rdata_c = vmmio_pkg::VERSION_VALUE;
              vmmio_pkg::OFF_DEVICE_ID:  rdata_c = {24'd0, device_type_id};
              vmmio_pkg::OFF_VENDOR_ID:  rdata_c = vmmio_pkg::VENDOR_VALUE;
              vmmio_pkg::OFF_HOST_FEAT:  rdata_c = (host_select == 32'd0) ? offered_features
                                                                         : 32'd0;
              vmmio_pkg::OFF_QUEUE_MAX:  rdata_c = vmmio_pkg::MAX_RING_SIZE;
              vmmio_pkg::OFF_QUEUE_PFN:  rdata_c = qread;
              vmmio_pkg::OFF_INT_STATUS: rdata_c = {24'd0, interrupt_status};
              vmmio_pkg::OFF_STATUS:     rdata_c = {24'd0, device_status};
              default:                   rdata_c = 32'd0;
            endcase
          end
        end
        vmmio_pkg::KIND_WRITE: begin
          if (reg_access) begin
            case (s1_offset)
              vmmio_pkg::OFF_HOST_SEL:  host_select_next = s1_value;
              vmmio_pkg::OFF_GUEST_FEAT: begin
                if (guest_select == 32'd0) begin
                  fvalid_c = 1'b1;
                  fbits_c  = s1_value;
                end
              end
              vmmio_pkg::OFF_GUEST_SEL: guest_select_next = s1_value;
              vmmio_pkg::OFF_PAGE_SIZE: page_shift_next = ctz32(s1_value);
              vmmio_pkg::OFF_QUEUE_SEL: begin
                if (s1_value < 32'(QUEUE_COUNT)) selected_queue_next = s1_value[QW-1:0];
              end
              vmmio_pkg::OFF_QUEUE_PFN: begin
                if (s1_value == 32'd0) dev_reset = 1'b1;
                else ram_we = 1'b1;
              end
              vmmio_pkg::OFF_QUEUE_NOTE: begin
                if (s1_value < 32'(QUEUE_COUNT)) begin
                  nvalid_c = 1'b1;
                  nqueue_c = s1_value[5:0];
                end
              end
              vmmio_pkg::OFF_INT_ACK:   interrupt_status_next = interrupt_status & ~s1_value[7:0];
              vmmio_pkg::OFF_STATUS: begin
                device_status_next = s1_value[7:0];
                if (s1_value[7:0] == 8'd0) dev_reset = 1'b1;
              end
              default: ;
            endcase
          end
        end
        vmmio_pkg::KIND_RAISE: interrupt_status_next = interrupt_status | s1_value[7:0];
        default: ;
      endcase

      // queue entry becomes valid when written
      if (ram_we) qvalid_next[selected_queue] = 1'b1;

      // device reset
      if (dev_reset) begin
        rpulse_c              = 1'b1;
        device_status_next    = 8'd0;
        interrupt_status_next = 8'd0;
        selected_queue_next   = '0;
        qvalid_next           = '0;
      end
    end
  end

  // queue table RAM, read at the next selected queue
  vmmio_ram #(
    .WIDTH($bits(vmmio_pkg::qentry_t)),
    .DEPTH(QUEUE_COUNT)
  ) u_qram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(selected_queue),
    .wdata(ram_wdata),
    .raddr(selected_queue_next),
    .rdata(ram_rdata)
  );

  // bypass of a write the RAM read could not see
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else begin
      byp_hit <= ram_we;
    end
    byp_data <= ram_wdata;
  end

  // transport state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      host_select      <= 32'd0;
      guest_select     <= 32'd0;
      page_shift       <= 5'd0;
      selected_queue   <= '0;
      interrupt_status <= 8'd0;
      device_status    <= 8'd0;
      qvalid           <= '0;
    end else begin
      host_select      <= host_select_next;
      guest_select     <= guest_select_next;
      page_shift       <= page_shift_next;
      selected_queue   <= selected_queue_next;
      interrupt_status <= interrupt_status_next;
      device_status    <= device_status_next;
      qvalid           <= qvalid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (adv) begin
      read_data         <= rdata_c;
      irq_level         <= (interrupt_status_next != 8'd0);
      notify_valid      <= nvalid_c;
      notify_queue      <= nqueue_c;
      features_valid    <= fvalid_c;
      accepted_features <= fbits_c;
      reset_pulse       <= rpulse_c;
    end
  end

  // configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == vmmio_pkg::CFG_FEATURES) ? offered_features
                                                        : {24'd0, device_type_id};

  always_ff @(posedge clk) begin
    if (rst) begin
      device_type_id   <= 8'd0;
      offered_features <= 32'd0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == vmmio_pkg::CFG_FEATURES) offered_features <= pwdata;
      else device_type_id <= pwdata[7:0];
    end
  end

endmodule

>>> src/vmmio_check.sv
// Port-level checker for the virtio MMIO register block, and its bind.
module vmmio_check (
  input logic        clk,
  input logic        rst,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [31:0] read_data,
  input logic        irq_level,
  input logic        notify_valid,
  input logic        features_valid,
  input logic        reset_pulse
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(reset_pulse))
    else $error("stalled result changed");

  // the input only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled with the result side free");

  // device reset clears interrupt status, so the IRQ level is low
  a_reset_irq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && reset_pulse |-> !irq_level)
    else $error("irq level high on device reset");

  // a notify comes from a write: no read data, no feature write, no reset
  a_notify_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && notify_valid |-> read_data == 32'd0 && !features_valid && !reset_pulse)
    else $error("notify transfer carries other effects");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind virtio_mmio_transport_registers_core vmmio_check u_vmmio_check (
  .clk           (clk),
  .rst           (rst),
  .req_stall     (req_stall),
  .rsp_valid     (rsp_valid),
  .rsp_stall     (rsp_stall),
  .read_data     (read_data),
  .irq_level     (irq_level),
  .notify_valid  (notify_valid),
  .features_valid(features_valid),
  .reset_pulse   (reset_pulse)
);
